@@ rtl/core/scl_pkg.sv @@
// shared types, constants and codes of the split l1 cache controller
package scl_pkg;

	localparam int ADDR_W    = 32;
	localparam int LINE_B    = 64;
	localparam int OFF_W     = $clog2(LINE_B);
	localparam int DSETS     = 16384;
	localparam int DSET_W    = $clog2(DSETS);
	localparam int DWAYS     = 4;
	localparam int DWAY_W    = $clog2(DWAYS);
	localparam int DAGE_W    = 2;
	localparam int DTAG_W    = ADDR_W - OFF_W - DSET_W;
	localparam int ISETS     = 16384;
	localparam int ISET_W    = $clog2(ISETS);
	localparam int IWAYS     = 2;
	localparam int IWAY_W    = $clog2(IWAYS);
	localparam int IAGE_W    = 1;
	localparam int ITAG_W    = ADDR_W - OFF_W - ISET_W;
	localparam int CLR_ROWS  = (DSETS > ISETS) ? DSETS : ISETS;
	localparam int CLR_W     = $clog2(CLR_ROWS);
	localparam int NRES      = 3;
	localparam int NRES_W    = 2;

	localparam logic [2:0] CMD_DREAD  = 3'd0;
	localparam logic [2:0] CMD_DWRITE = 3'd1;
	localparam logic [2:0] CMD_IFETCH = 3'd2;
	localparam logic [2:0] CMD_INVAL  = 3'd3;
	localparam logic [2:0] CMD_SNOOP  = 3'd4;
	localparam logic [2:0] CMD_CLEAR  = 3'd5;

	localparam logic [1:0] ST_I = 2'd0;
	localparam logic [1:0] ST_S = 2'd1;
	localparam logic [1:0] ST_E = 2'd2;
	localparam logic [1:0] ST_M = 2'd3;

	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_RETURN = 3'd1;
	localparam logic [2:0] OP_WRITE  = 3'd2;
	localparam logic [2:0] OP_READ   = 3'd3;
	localparam logic [2:0] OP_RFO    = 3'd4;

	localparam logic [1:0] EV_OK      = 2'd0;
	localparam logic [1:0] EV_REFUSED = 2'd1;
	localparam logic [1:0] EV_ABSENT  = 2'd2;

	typedef struct packed {
		logic [DTAG_W-1:0] tag;
		logic [1:0]        st;
		logic [DAGE_W-1:0] age;
	} dway_t;

	typedef dway_t [DWAYS-1:0] drow_t;

	typedef struct packed {
		logic [ITAG_W-1:0] tag;
		logic              v;
		logic [IAGE_W-1:0] age;
	} iway_t;

	typedef iway_t [IWAYS-1:0] irow_t;

	typedef struct packed {
		logic [2:0]        cmd;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic [2:0]        l2_op;
		logic [ADDR_W-1:0] line_address;
		logic [1:0]        event_status;
		logic              last;
	} rsp_t;

	typedef struct packed {
		logic              hit;
		logic              wb;
		logic [DTAG_W-1:0] wb_tag;
		logic [2:0]        op;
		logic              rfo_wr;
		logic [1:0]        status;
	} dres_t;

	typedef struct packed {
		logic       hit;
		logic [2:0] op;
	} ires_t;

endpackage

@@ rtl/core/split_l1_cache_mesi_lru.sv @@
// top level of the split l1 cache tag and state controller
//
// Requests enter on req (cmd and byte address) and are taken at a rising
// edge with start high and busy low. Each request of commands 0 to 5 gives
// one to three results on rsp, one per cycle, each marked by valid for
// exactly one cycle; the last result of a request has rsp.last set. The
// receiver cannot hold results off.
// A lookup reads the set row from the tag ram as the request is taken,
// compares ways and writes the updated row back in the look state, then
// gives its results in the emit state; busy stays high until the last
// result. Clear all walks both tag rams, one set per cycle, then gives
// its one result. Commands 6 and 7 are taken and give no result.
// After reset the same sweep runs with busy high and no result, leaving
// every line invalid and every age zero.
module split_l1_cache_mesi_lru (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  scl_pkg::req_t req,
	output logic          valid,
	output scl_pkg::rsp_t rsp
);

	localparam logic [1:0] S_SWEEP = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_LOOK  = 2'd2;
	localparam logic [1:0] S_EMIT  = 2'd3;

	logic [1:0]                   state_q;
	logic [scl_pkg::CLR_W-1:0]    cnt_q;
	logic                         clr_res_q;
	logic [2:0]                   cmd_q;
	logic [scl_pkg::ADDR_W-1:0]   addr_q;
	scl_pkg::rsp_t                res_q [scl_pkg::NRES];
	logic [scl_pkg::NRES_W-1:0]   n_q;
	logic [scl_pkg::NRES_W-1:0]   idx_q;

	scl_pkg::drow_t               drow_rd;
	scl_pkg::drow_t               drow_wr;
	scl_pkg::irow_t               irow_rd;
	scl_pkg::irow_t               irow_wr;
	scl_pkg::dres_t               dres;
	scl_pkg::ires_t               ires;
	scl_pkg::rsp_t                ent [scl_pkg::NRES];
	logic [scl_pkg::NRES_W-1:0]   k;
	logic [scl_pkg::ADDR_W-1:0]   line;
	logic [scl_pkg::DSET_W-1:0]   dset_q;
	logic [scl_pkg::ISET_W-1:0]   iset_q;
	logic                         accept;
	logic                         sweep;
	logic                         we;
	logic [scl_pkg::DSET_W-1:0]   dwaddr;
	logic [scl_pkg::ISET_W-1:0]   iwaddr;

	assign accept = start && !busy;
	assign busy = (state_q != S_IDLE);
	assign sweep = (state_q == S_SWEEP);
	assign line = {addr_q[scl_pkg::ADDR_W-1:scl_pkg::OFF_W], {scl_pkg::OFF_W{1'b0}}};
	assign dset_q = addr_q[scl_pkg::OFF_W +: scl_pkg::DSET_W];
	assign iset_q = addr_q[scl_pkg::OFF_W +: scl_pkg::ISET_W];
	assign we = sweep || (state_q == S_LOOK);
	assign dwaddr = sweep ? cnt_q[scl_pkg::DSET_W-1:0] : dset_q;
	assign iwaddr = sweep ? cnt_q[scl_pkg::ISET_W-1:0] : iset_q;

	scl_ram #(
		.WIDTH($bits(scl_pkg::drow_t)),
		.DEPTH(scl_pkg::DSETS)
	) u_dram (
		.clk(clk),
		.we(we),
		.waddr(dwaddr),
		.wdata(sweep ? '0 : drow_wr),
		.raddr(req.address[scl_pkg::OFF_W +: scl_pkg::DSET_W]),
		.rdata(drow_rd)
	);

	scl_ram #(
		.WIDTH($bits(scl_pkg::irow_t)),
		.DEPTH(scl_pkg::ISETS)
	) u_iram (
		.clk(clk),
		.we(we),
		.waddr(iwaddr),
		.wdata(sweep ? '0 : irow_wr),
		.raddr(req.address[scl_pkg::OFF_W +: scl_pkg::ISET_W]),
		.rdata(irow_rd)
	);

	scl_dset u_dset (
		.cmd(cmd_q),
		.tag(addr_q[scl_pkg::ADDR_W-1 -: scl_pkg::DTAG_W]),
		.row_in(drow_rd),
		.row_out(drow_wr),
		.res(dres)
	);

	scl_iset u_iset (
		.fetch(cmd_q == scl_pkg::CMD_IFETCH),
		.tag(addr_q[scl_pkg::ADDR_W-1 -: scl_pkg::ITAG_W]),
		.row_in(irow_rd),
		.row_out(irow_wr),
		.res(ires)
	);

	// result list of one lookup
	always_comb begin
		for (int i = 0; i < scl_pkg::NRES; i++) begin
			ent[i] = '0;
		end
		k = '0;
		if (cmd_q == scl_pkg::CMD_IFETCH) begin
			ent[0].hit = ires.hit;
			ent[0].l2_op = ires.op;
			ent[0].line_address = line;
			k = 2'd1;
		end else begin
			if (dres.wb) begin
				ent[k].l2_op = scl_pkg::OP_WRITE;
				ent[k].line_address = {dres.wb_tag, dset_q, {scl_pkg::OFF_W{1'b0}}};
				k = k + 1'b1;
			end
			ent[k].hit = dres.hit;
			ent[k].l2_op = dres.op;
			ent[k].line_address = line;
			ent[k].event_status = dres.status;
			k = k + 1'b1;
			if (dres.rfo_wr) begin
				ent[k].l2_op = scl_pkg::OP_WRITE;
				ent[k].line_address = line;
				k = k + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			cnt_q <= '0;
			clr_res_q <= 1'b0;
			n_q <= '0;
			idx_q <= '0;
		end else begin
			unique case (state_q)
				S_SWEEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == scl_pkg::CLR_W'(scl_pkg::CLR_ROWS - 1)) begin
						cnt_q <= '0;
						if (clr_res_q) begin
							clr_res_q <= 1'b0;
							n_q <= 2'd1;
							idx_q <= '0;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (req.cmd == scl_pkg::CMD_CLEAR) begin
							clr_res_q <= 1'b1;
							state_q <= S_SWEEP;
						end else if (req.cmd < scl_pkg::CMD_CLEAR) begin
							state_q <= S_LOOK;
						end
					end
				end
				S_LOOK: begin
					n_q <= k;
					idx_q <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == n_q - 1'b1) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.cmd;
			addr_q <= req.address;
		end
		if (state_q == S_LOOK) begin
			for (int i = 0; i < scl_pkg::NRES; i++) begin
				res_q[i] <= ent[i];
			end
		end else if (sweep && clr_res_q) begin
			res_q[0] <= '0;
		end
	end

	always_comb begin
		rsp = res_q[idx_q];
		rsp.last = (idx_q == n_q - 1'b1);
	end

	assign valid = (state_q == S_EMIT);

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		valid && rsp.last |=> !valid)
		else $error("result after last");

	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !rsp.last |=> valid)
		else $error("result sequence broken");

	a_busy_emit: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> busy)
		else $error("request taken while emitting");

	a_sweep_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		sweep |-> !valid && busy)
		else $error("result during sweep");

endmodule

@@ rtl/core/scl_ram.sv @@
// generic single write port ram with registered read
module scl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/scl_dset.sv @@
// data cache set update: lookup, victim choice, mesi and lru changes
module scl_dset (
	input  logic [2:0]                 cmd,
	input  logic [scl_pkg::DTAG_W-1:0] tag,
	input  scl_pkg::drow_t             row_in,
	output scl_pkg::drow_t             row_out,
	output scl_pkg::dres_t             res
);

	localparam logic [scl_pkg::DAGE_W-1:0] AGE_MAX = scl_pkg::DAGE_W'(scl_pkg::DWAYS - 1);

	logic                          hit;
	logic [scl_pkg::DWAY_W-1:0]    hw;
	logic                          vfound;
	logic [scl_pkg::DWAY_W-1:0]    vw;
	logic [scl_pkg::DAGE_W-1:0]    h;

	always_comb begin
		hit = 1'b0;
		hw = '0;
		for (int i = 0; i < scl_pkg::DWAYS; i++) begin
			if (!hit && row_in[i].st != scl_pkg::ST_I && row_in[i].tag == tag) begin
				hit = 1'b1;
				hw = scl_pkg::DWAY_W'(i);
			end
		end
		vfound = 1'b0;
		vw = '0;
		for (int i = 0; i < scl_pkg::DWAYS; i++) begin
			if (!vfound && row_in[i].st == scl_pkg::ST_I) begin
				vfound = 1'b1;
				vw = scl_pkg::DWAY_W'(i);
			end
		end
		for (int i = 0; i < scl_pkg::DWAYS; i++) begin
			if (!vfound && row_in[i].age == AGE_MAX) begin
				vfound = 1'b1;
				vw = scl_pkg::DWAY_W'(i);
			end
		end
	end

	always_comb begin
		row_out = row_in;
		res = '0;
		res.hit = hit;
		h = row_in[hw].age;
		case (cmd)
			scl_pkg::CMD_DREAD, scl_pkg::CMD_DWRITE: begin
				if (hit) begin
					for (int i = 0; i < scl_pkg::DWAYS; i++) begin
						if (row_in[i].st != scl_pkg::ST_I && row_in[i].age < h) begin
							row_out[i].age = row_in[i].age + 1'b1;
						end
					end
					row_out[hw].age = '0;
					if (cmd == scl_pkg::CMD_DWRITE) begin
						if (row_in[hw].st == scl_pkg::ST_S) begin
							row_out[hw].st = scl_pkg::ST_E;
							res.op = scl_pkg::OP_WRITE;
						end else begin
							row_out[hw].st = scl_pkg::ST_M;
						end
					end
				end else begin
					res.wb = (row_in[vw].st == scl_pkg::ST_M);
					res.wb_tag = row_in[vw].tag;
					for (int i = 0; i < scl_pkg::DWAYS; i++) begin
						if (scl_pkg::DWAY_W'(i) != vw && row_in[i].st != scl_pkg::ST_I) begin
							row_out[i].age = row_in[i].age + 1'b1;
						end
					end
					row_out[vw].age = '0;
					row_out[vw].tag = tag;
					if (cmd == scl_pkg::CMD_DREAD) begin
						row_out[vw].st = scl_pkg::ST_S;
						res.op = scl_pkg::OP_READ;
					end else begin
						row_out[vw].st = scl_pkg::ST_E;
						res.op = scl_pkg::OP_RFO;
						res.rfo_wr = 1'b1;
					end
				end
			end
			scl_pkg::CMD_INVAL: begin
				if (!hit) begin
					res.status = scl_pkg::EV_ABSENT;
				end else if (row_in[hw].st == scl_pkg::ST_M) begin
					res.status = scl_pkg::EV_REFUSED;
				end else begin
					for (int i = 0; i < scl_pkg::DWAYS; i++) begin
						if (row_in[i].st != scl_pkg::ST_I && row_in[i].age > h) begin
							row_out[i].age = row_in[i].age - 1'b1;
						end
					end
					row_out[hw].st = scl_pkg::ST_I;
				end
			end
			scl_pkg::CMD_SNOOP: begin
				if (!hit) begin
					res.status = scl_pkg::EV_ABSENT;
				end else begin
					if (row_in[hw].st == scl_pkg::ST_M) begin
						res.op = scl_pkg::OP_RETURN;
					end
					row_out[hw].st = scl_pkg::ST_S;
				end
			end
			default: begin
				row_out = row_in;
			end
		endcase
	end

endmodule

@@ rtl/core/scl_iset.sv @@
// instruction cache set update: lookup, victim choice and lru changes
module scl_iset (
	input  logic                       fetch,
	input  logic [scl_pkg::ITAG_W-1:0] tag,
	input  scl_pkg::irow_t             row_in,
	output scl_pkg::irow_t             row_out,
	output scl_pkg::ires_t             res
);

	localparam logic [scl_pkg::IAGE_W-1:0] AGE_MAX = scl_pkg::IAGE_W'(scl_pkg::IWAYS - 1);

	logic                       hit;
	logic [scl_pkg::IWAY_W-1:0] hw;
	logic                       vfound;
	logic [scl_pkg::IWAY_W-1:0] vw;
	logic [scl_pkg::IAGE_W-1:0] h;

	always_comb begin
		hit = 1'b0;
		hw = '0;
		vfound = 1'b0;
		vw = '0;
		for (int i = 0; i < scl_pkg::IWAYS; i++) begin
			if (!hit && row_in[i].v && row_in[i].tag == tag) begin
				hit = 1'b1;
				hw = scl_pkg::IWAY_W'(i);
			end
		end
		for (int i = 0; i < scl_pkg::IWAYS; i++) begin
			if (!vfound && !row_in[i].v) begin
				vfound = 1'b1;
				vw = scl_pkg::IWAY_W'(i);
			end
		end
		for (int i = 0; i < scl_pkg::IWAYS; i++) begin
			if (!vfound && row_in[i].age == AGE_MAX) begin
				vfound = 1'b1;
				vw = scl_pkg::IWAY_W'(i);
			end
		end
	end

	always_comb begin
		row_out = row_in;
		res.hit = hit;
		res.op = hit ? scl_pkg::OP_NONE : scl_pkg::OP_READ;
		h = row_in[hw].age;
		if (fetch) begin
			if (hit) begin
				for (int i = 0; i < scl_pkg::IWAYS; i++) begin
					if (row_in[i].v && row_in[i].age < h) begin
						row_out[i].age = row_in[i].age + 1'b1;
					end
				end
				row_out[hw].age = '0;
			end else begin
				for (int i = 0; i < scl_pkg::IWAYS; i++) begin
					if (scl_pkg::IWAY_W'(i) != vw && row_in[i].v) begin
						row_out[i].age = row_in[i].age + 1'b1;
					end
				end
				row_out[vw].age = '0;
				row_out[vw].v = 1'b1;
				row_out[vw].tag = tag;
			end
		end
	end

endmodule

@@ bench/tb_split_l1_cache_mesi_lru.sv @@
// testbench for the split l1 cache controller: scoreboard with a cache predictor and stimulus
`timescale 1ns / 100ps

module tb_split_l1_cache_mesi_lru;

	class cache_scoreboard;
		logic [scl_pkg::DTAG_W-1:0] dtag [scl_pkg::DSETS][scl_pkg::DWAYS];
		logic [1:0]                 dst  [scl_pkg::DSETS][scl_pkg::DWAYS];
		int unsigned                dage [scl_pkg::DSETS][scl_pkg::DWAYS];
		logic [scl_pkg::ITAG_W-1:0] itag [scl_pkg::ISETS][scl_pkg::IWAYS];
		bit                         ival [scl_pkg::ISETS][scl_pkg::IWAYS];
		int unsigned                iage [scl_pkg::ISETS][scl_pkg::IWAYS];
		scl_pkg::rsp_t              pending [$];
		int                         errors;
		int                         checked;

		function void clear_all();
			foreach (dst[s, w]) begin
				dst[s][w] = scl_pkg::ST_I;
				dage[s][w] = 0;
			end
			foreach (ival[s, w]) begin
				ival[s][w] = 0;
				iage[s][w] = 0;
			end
		endfunction

		function void push(bit h, logic [2:0] op, logic [31:0] la, logic [1:0] ev);
			scl_pkg::rsp_t r;
			r.hit = h;
			r.l2_op = op;
			r.line_address = la;
			r.event_status = ev;
			r.last = 0;
			pending.push_back(r);
		endfunction

		function void note_request(scl_pkg::req_t q);
			logic [31:0] la;
			int ds, is, w, v, n0, i;
			int unsigned hage;
			la = {q.address[31:scl_pkg::OFF_W], {scl_pkg::OFF_W{1'b0}}};
			ds = int'(q.address[scl_pkg::OFF_W +: scl_pkg::DSET_W]);
			is = int'(q.address[scl_pkg::OFF_W +: scl_pkg::ISET_W]);
			n0 = pending.size();
			w = -1;
			if (q.cmd > scl_pkg::CMD_CLEAR)
				return;
			if (q.cmd == scl_pkg::CMD_IFETCH) begin
				for (i = 0; i < scl_pkg::IWAYS; i++)
					if (w < 0 && ival[is][i] && itag[is][i] == q.address[31 -: scl_pkg::ITAG_W])
						w = i;
				if (w >= 0) begin
					hage = iage[is][w];
					for (i = 0; i < scl_pkg::IWAYS; i++)
						if (ival[is][i] && iage[is][i] < hage)
							iage[is][i]++;
					iage[is][w] = 0;
					push(1, scl_pkg::OP_NONE, la, scl_pkg::EV_OK);
				end else begin
					v = -1;
					for (i = 0; i < scl_pkg::IWAYS; i++)
						if (v < 0 && !ival[is][i])
							v = i;
					for (i = 0; i < scl_pkg::IWAYS; i++)
						if (v < 0 && iage[is][i] == scl_pkg::IWAYS - 1)
							v = i;
					if (v < 0)
						v = 0;
					iage[is][v] = 0;
					for (i = 0; i < scl_pkg::IWAYS; i++)
						if (i != v && ival[is][i] && iage[is][i] < 255)
							iage[is][i]++;
					ival[is][v] = 1;
					itag[is][v] = q.address[31 -: scl_pkg::ITAG_W];
					push(0, scl_pkg::OP_READ, la, scl_pkg::EV_OK);
				end
			end else if (q.cmd == scl_pkg::CMD_CLEAR) begin
				clear_all();
				push(0, scl_pkg::OP_NONE, '0, scl_pkg::EV_OK);
			end else begin
				for (i = 0; i < scl_pkg::DWAYS; i++)
					if (w < 0 && dst[ds][i] != scl_pkg::ST_I &&
						dtag[ds][i] == q.address[31 -: scl_pkg::DTAG_W])
						w = i;
				if (q.cmd == scl_pkg::CMD_DREAD || q.cmd == scl_pkg::CMD_DWRITE) begin
					if (w >= 0) begin
						hage = dage[ds][w];
						for (i = 0; i < scl_pkg::DWAYS; i++)
							if (dst[ds][i] != scl_pkg::ST_I && dage[ds][i] < hage)
								dage[ds][i]++;
						dage[ds][w] = 0;
						if (q.cmd == scl_pkg::CMD_DREAD)
							push(1, scl_pkg::OP_NONE, la, scl_pkg::EV_OK);
						else if (dst[ds][w] == scl_pkg::ST_S) begin
							dst[ds][w] = scl_pkg::ST_E;
							push(1, scl_pkg::OP_WRITE, la, scl_pkg::EV_OK);
						end else begin
							dst[ds][w] = scl_pkg::ST_M;
							push(1, scl_pkg::OP_NONE, la, scl_pkg::EV_OK);
						end
					end else begin
						v = -1;
						for (i = 0; i < scl_pkg::DWAYS; i++)
							if (v < 0 && dst[ds][i] == scl_pkg::ST_I)
								v = i;
						for (i = 0; i < scl_pkg::DWAYS; i++)
							if (v < 0 && dage[ds][i] == scl_pkg::DWAYS - 1)
								v = i;
						if (v < 0)
							v = 0;
						if (dst[ds][v] == scl_pkg::ST_M)
							push(0, scl_pkg::OP_WRITE, {dtag[ds][v], ds[scl_pkg::DSET_W-1:0],
								{scl_pkg::OFF_W{1'b0}}}, scl_pkg::EV_OK);
						dage[ds][v] = 0;
						for (i = 0; i < scl_pkg::DWAYS; i++)
							if (i != v && dst[ds][i] != scl_pkg::ST_I && dage[ds][i] < 255)
								dage[ds][i]++;
						if (q.cmd == scl_pkg::CMD_DREAD) begin
							push(0, scl_pkg::OP_READ, la, scl_pkg::EV_OK);
							dst[ds][v] = scl_pkg::ST_S;
						end else begin
							push(0, scl_pkg::OP_RFO, la, scl_pkg::EV_OK);
							push(0, scl_pkg::OP_WRITE, la, scl_pkg::EV_OK);
							dst[ds][v] = scl_pkg::ST_E;
						end
						dtag[ds][v] = q.address[31 -: scl_pkg::DTAG_W];
					end
				end else if (q.cmd == scl_pkg::CMD_INVAL) begin
					if (w < 0)
						push(0, scl_pkg::OP_NONE, la, scl_pkg::EV_ABSENT);
					else if (dst[ds][w] == scl_pkg::ST_M)
						push(1, scl_pkg::OP_NONE, la, scl_pkg::EV_REFUSED);
					else begin
						hage = dage[ds][w];
						for (i = 0; i < scl_pkg::DWAYS; i++)
							if (dst[ds][i] != scl_pkg::ST_I && dage[ds][i] > hage)
								dage[ds][i]--;
						dst[ds][w] = scl_pkg::ST_I;
						push(1, scl_pkg::OP_NONE, la, scl_pkg::EV_OK);
					end
				end else begin
					if (w < 0)
						push(0, scl_pkg::OP_NONE, la, scl_pkg::EV_ABSENT);
					else begin
						push(1, dst[ds][w] == scl_pkg::ST_M ? scl_pkg::OP_RETURN :
							scl_pkg::OP_NONE, la, scl_pkg::EV_OK);
						dst[ds][w] = scl_pkg::ST_S;
					end
				end
			end
			if (pending.size() > n0)
				pending[pending.size() - 1].last = 1;
		endfunction

		function void check_result(scl_pkg::rsp_t got);
			scl_pkg::rsp_t exp_r;
			checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %p", got);
				return;
			end
			exp_r = pending.pop_front();
			if (got !== exp_r) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected %p got %p", exp_r, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	scl_pkg::req_t req = '0;
	logic busy, valid;
	scl_pkg::rsp_t rsp;
	cache_scoreboard sb;
	int idle_cycles = 0;
	int sent = 0;
	int cmd_seen [8];
	logic [31:0] pool [8];

	localparam int WATCHDOG = 100000;

	split_l1_cache_mesi_lru dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .valid(valid), .rsp(rsp)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (valid)
			sb.check_result(rsp);
		if ((start && !busy) || valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog expired");
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// start stays high after the request is taken; drain and a gap with a nonzero count drop it
	task automatic send(logic [2:0] c, logic [31:0] a);
		scl_pkg::req_t q;
		q.cmd = c;
		q.address = a;
		start <= 1;
		req <= q;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_request(q);
		cmd_seen[c]++;
		sent++;
	endtask

	task automatic gap(int n);
		if (n > 0)
			start <= 0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		start <= 0;
		do
			@(posedge clk);
		while (sb.pending.size() != 0);
		repeat (7) @(posedge clk);
	endtask

	// pool addresses share a set with distinct tags, to force evictions; one pick in ten is random
	function automatic logic [31:0] pick_addr();
		logic [31:0] a;
		a = pool[$urandom_range(0, 7)];
		if ($urandom_range(0, 9) == 0)
			a = $urandom();
		else
			a[scl_pkg::OFF_W-1:0] = scl_pkg::OFF_W'($urandom());
		return a;
	endfunction

	initial begin
		int i, burst;
		logic [2:0] c;
		sb = new();
		sb.clear_all();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		for (i = 0; i < 8; i++)
			pool[i] = {i[11:0] ^ (i[0] ? 12'hfff : 12'h000), 14'h0155, 6'h0};

		send(scl_pkg::CMD_DREAD, 32'h0000_0000);
		send(scl_pkg::CMD_DREAD, 32'hffff_ffff);
		send(scl_pkg::CMD_DWRITE, 32'hffff_ffc0);
		send(scl_pkg::CMD_DWRITE, 32'hffff_ffc1);
		send(scl_pkg::CMD_DWRITE, 32'h0000_003f);
		for (i = 0; i < 5; i++)
			send(scl_pkg::CMD_DWRITE, pool[i]);
		send(scl_pkg::CMD_DREAD, pool[5]);
		send(scl_pkg::CMD_SNOOP, pool[4]);
		send(scl_pkg::CMD_SNOOP, pool[3]);
		send(scl_pkg::CMD_SNOOP, 32'h1234_5678);
		send(scl_pkg::CMD_INVAL, pool[4]);
		send(scl_pkg::CMD_DWRITE, pool[3]);
		send(scl_pkg::CMD_INVAL, pool[3]);
		send(scl_pkg::CMD_INVAL, 32'h0bad_0000);
		send(scl_pkg::CMD_IFETCH, 32'h0000_0000);
		send(scl_pkg::CMD_IFETCH, 32'hffff_ffff);
		send(scl_pkg::CMD_IFETCH, 32'h0000_0000);
		send(3'd6, 32'haaaa_aaaa);
		send(3'd7, 32'h5555_5555);
		send(scl_pkg::CMD_CLEAR, 32'hffff_ffff);
		send(scl_pkg::CMD_DREAD, 32'hffff_ffff);
		drain();

		while (sent < 410) begin
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				case ($urandom_range(0, 99))
					0: c = scl_pkg::CMD_CLEAR;
					1, 2: c = 3'd6 + 3'($urandom_range(0, 1));
					default: c = 3'($urandom_range(0, 4));
				endcase
				if (sent > 200 && sent < 206)
					c = scl_pkg::CMD_CLEAR;
				send(c, pick_addr());
			end
			if ($urandom_range(0, 3) == 0)
				drain();
			else
				gap($urandom_range(0, 6));
		end
		drain();
		gap(50);

		$display("sent %0d requests (read %0d write %0d fetch %0d inval %0d snoop %0d",
			sent, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], cmd_seen[4]);
		$display("clear %0d unused %0d), checked %0d results, %0d mismatches",
			cmd_seen[5], cmd_seen[6] + cmd_seen[7], sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

@@ filelist.f @@
rtl/core/scl_pkg.sv
rtl/core/scl_ram.sv
rtl/core/scl_dset.sv
rtl/core/scl_iset.sv
rtl/core/split_l1_cache_mesi_lru.sv
bench/tb_split_l1_cache_mesi_lru.sv
